// ===== rtl/arpc_pkg.sv =====
// shared types and constants for the arp cache table
package arpc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int IP_W = 32;
  localparam int MAC_W = 48;
  localparam int ENTRY_W = IP_W + MAC_W;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_LEARN  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_LOOKUP = 2'd0,
    ST_INSERT = 2'd1,
    ST_UPDATE = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } arpc_state_e;

  typedef struct packed {
    logic             mode;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;
  } arpc_in_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac_found;
    status_e          status;
  } arpc_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } arpc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } arpc_stat_t;

endpackage

// ===== rtl/arpc_ctrl.sv =====
// sequencer for one lookup or learn word: accept, scan, drain, commit
module arpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  arpc_pkg::arpc_stat_t stat_i,
  output arpc_pkg::arpc_cmd_t  cmd_o
);
  import arpc_pkg::*;

  arpc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      S_DRAIN: begin
        cmd_o = '0;
      end
      S_DONE: begin
        cmd_o.commit = stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/arpc_dp.sv =====
// datapath: entry store, scan pointer, ip comparator, result register
module arpc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arpc_pkg::arpc_in_t  in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output arpc_pkg::arpc_out_t out_data_o,
  input  arpc_pkg::arpc_cmd_t cmd_i,
  output arpc_pkg::arpc_stat_t stat_o
);
  import arpc_pkg::*;

  // entry store, one row holds ip and mac
  logic [ENTRY_W-1:0] mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  arpc_in_t req_q;

  logic [IDX_W-1:0] issue_q, issue_d;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             pipe_vld_q;
  logic [ENTRY_W-1:0] rd_q;

  logic             match_q, match_d;
  logic [IDX_W-1:0] match_idx_q, match_idx_d;
  logic [MAC_W-1:0] mac_hit_q, mac_hit_d;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;

  logic             out_valid_q, out_valid_d;
  arpc_out_t        out_q, out_d;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [IP_W-1:0]  rd_ip;
  logic [MAC_W-1:0] rd_mac;
  logic             rd_valid;

  assign rd_ip    = rd_q[ENTRY_W-1:MAC_W];
  assign rd_mac   = rd_q[MAC_W-1:0];
  assign rd_valid = valid_q[cmp_idx_q];

  assign stat_o.scan_last = (issue_q == IDX_W'(TABLE_ENTRIES - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
  end

  // scan pointer
  always_comb begin
    issue_d = issue_q;
    if (cmd_i.load) begin
      issue_d = '0;
    end else if (cmd_i.scan && !stat_o.scan_last) begin
      issue_d = issue_q + 1'b1;
    end
  end

  // registered read of the store
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      rd_q      <= mem_q[issue_q];
      cmp_idx_q <= issue_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= {req_q.ip_addr, req_q.mac_addr};
  end

  // compare stage: first matching valid entry, first free entry
  always_comb begin
    match_d     = match_q;
    match_idx_d = match_idx_q;
    mac_hit_d   = mac_hit_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    if (cmd_i.load) begin
      match_d = 1'b0;
      free_d  = 1'b0;
    end else if (pipe_vld_q) begin
      if (rd_valid && (rd_ip == req_q.ip_addr) && !match_q) begin
        match_d     = 1'b1;
        match_idx_d = cmp_idx_q;
        mac_hit_d   = rd_mac;
      end
      if (!rd_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end
  end

  // decision and result
  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = match_idx_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.commit) begin
      out_valid_d     = 1'b1;
      out_d.hit       = 1'b0;
      out_d.mac_found = '0;
      if (req_q.mode == MODE_LOOKUP) begin
        out_d.status = ST_LOOKUP;
        if (match_q) begin
          out_d.hit       = 1'b1;
          out_d.mac_found = mac_hit_q;
        end
      end else if (match_q) begin
        wr_en        = 1'b1;
        out_d.hit    = 1'b1;
        out_d.status = ST_UPDATE;
      end else if (free_q) begin
        wr_en           = 1'b1;
        wr_idx          = free_idx_q;
        valid_d[free_idx_q] = 1'b1;
        out_d.status    = ST_INSERT;
      end else begin
        out_d.status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      issue_q     <= '0;
      pipe_vld_q  <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      issue_q     <= issue_d;
      pipe_vld_q  <= cmd_i.scan;
      match_q     <= match_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q <= match_idx_d;
    mac_hit_q   <= mac_hit_d;
    free_idx_q  <= free_idx_d;
    out_q       <= out_d;
  end

endmodule

// ===== rtl/arp_cache_table_unit.sv =====
// top level of the arp cache table: ip to mac lookup and learning
//
// A fixed table of TABLE_ENTRIES (16) entries that maps IPv4 addresses to
// MAC addresses. Each input word is a lookup (mode 0) or a learn (mode 1)
// and yields exactly one result word. Every word walks all entries with a
// single ip comparator, one entry per cycle through a registered read of
// the entry store: a scan step per entry, a drain step to compare the last
// entry read, and a commit step that writes the store and loads the result
// register once the output register is free. One word is worked on at a
// time; the next word is accepted as soon as the previous one is committed,
// even while its result still waits in the output register.
// A learn hit rewrites the mac of the matching entry, a learn miss fills
// the lowest-numbered free entry, and a learn into a full table is dropped
// and reported with the full status. After reset every entry is invalid.
module arp_cache_table_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  arpc_pkg::arpc_in_t  in_data_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output arpc_pkg::arpc_out_t out_data_o
);
  import arpc_pkg::*;

  // command and status between sequencer and datapath
  arpc_cmd_t  cmd;
  arpc_stat_t stat;

  // sequencer: idle, scan over entries, drain compare, commit
  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // entry store, valid bits, comparator and result register
  arpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
